/* src/c3sc_pkg.sv */
// Shared constants for the 3x3 sharpening convolution block.
// No dependencies.
`default_nettype none

package c3sc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int ROW_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd32;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd32;

    // Accumulator: -3952 .. 7523 after the rounding offset.
    localparam int ACC_W = 15;
    localparam logic signed [ACC_W-1:0] ACC_OFFSET = 15'sd128;

    // Divide by 13: acc * 5042 >> 16 is exact for 0 <= acc < 3328.
    localparam int               DIV_IN_W  = 12;
    localparam int               DIV_MUL_W = 13;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5042;
    localparam int               DIV_SHIFT = 16;
    localparam logic signed [ACC_W-1:0] ACC_SAT = 15'sd3328;

endpackage

`default_nettype wire

/* src/c3sc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module c3sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/conv3x3_sharpen_clip.sv */
// 3x3 sharpening convolution with clipping over a raster pixel stream.
// Depends on c3sc_pkg and c3sc_ram.
//
// Usage:
//   Pixels enter in raster order on pixel/in_valid/in_stall, one transfer
//   per accepted pixel. Each interior pixel yields one result transfer on
//   value/out_row/out_col/frame_last with out_valid/out_stall; border
//   pixels yield nothing. frame_last marks the last interior pixel.
//   frame_width (index 0) and frame_height (index 1) are written through cfg_valid/
//   cfg_ready/cfg_index/cfg_data; cfg_ready is always high. The user must write them
//   only while the block is idle; the block itself does not enforce it. Throughput:
//   one pixel per cycle while in_stall is low. The two line stores share one RAM
//   whose entry for the next column is read while the current pixel is written,
//   so the registered read is ready for the next pixel. The accepting edge loads
//   the kernel sum into the sum stage; it is then divided by 13, clipped and loaded
//   into the output register. While out_valid and out_stall are both high the output
//   register holds; one more result may sit in the sum stage, after which in_stall rises.
//   Reset clears counters, window and pipeline; the width and height
//   return to 32. Line-store contents are not cleared: rows 0 and 1 of a
//   frame fill them before they are used.
`default_nettype none

module conv3x3_sharpen_clip #(
    parameter int MAX_WIDTH = c3sc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [c3sc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [c3sc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic [c3sc_pkg::PIX_W-1:0]       pixel,

    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic [c3sc_pkg::PIX_W-1:0]       value,
    output      logic [c3sc_pkg::ROW_W-1:0]       out_row,
    output      logic [$clog2(MAX_WIDTH)-1:0]     out_col,
    output      logic                             frame_last
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CW + 1 > c3sc_pkg::FW_W) ? CW + 1 : c3sc_pkg::FW_W;
    localparam int PW  = c3sc_pkg::PIX_W;
    localparam int RW  = c3sc_pkg::ROW_W;
    localparam int AW  = c3sc_pkg::ACC_W;
    localparam int PRW = c3sc_pkg::DIV_IN_W + c3sc_pkg::DIV_MUL_W;

    localparam logic [WW-1:0] W_MIN = WW'(3);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [RW-1:0] H_MIN = RW'(3);

    // Configuration
    logic [c3sc_pkg::FW_W-1:0] frame_width_reg;
    logic [c3sc_pkg::FH_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= c3sc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= c3sc_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == c3sc_pkg::REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[c3sc_pkg::FW_W-1:0];
            end
            else if (cfg_index == c3sc_pkg::REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data[c3sc_pkg::FH_W-1:0];
            end
        end
    end

    logic [WW-1:0] w_ext;
    logic [WW-1:0] w_use;
    logic [RW-1:0] h_use;

    always_comb
    begin
        w_ext = WW'(frame_width_reg);
        priority if (w_ext < W_MIN)
        begin
            w_use = W_MIN;
        end
        else if (w_ext > W_MAX)
        begin
            w_use = W_MAX;
        end
        else
        begin
            w_use = w_ext;
        end
        h_use = (frame_height_reg < H_MIN) ? H_MIN : frame_height_reg;
    end

    // Pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s1_en;
    logic accept;

    assign out_en   = !out_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || out_en;
    assign in_stall = !s1_en;
    assign accept   = in_valid && !in_stall;

    // Position counters
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [WW-1:0] col_inc;
    logic [RW:0]   row_inc;
    logic          col_wrap;

    always_comb
    begin
        col_inc  = WW'(col_reg) + WW'(1);
        row_inc  = {1'b0, row_reg} + (RW+1)'(1);
        col_wrap = (col_inc >= w_use);
        col_next = col_wrap ? '0 : col_inc[CW-1:0];
        if (!col_wrap)
        begin
            row_next = row_reg;
        end
        else if (row_inc >= {1'b0, h_use})
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_inc[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: [2*PW-1:PW] two rows above, [PW-1:0] row above.
    // The entry for the next column is prefetched on each transfer.
    logic [2*PW-1:0] line_rd;
    logic [PW-1:0]   top2;
    logic [PW-1:0]   mid2;

    assign top2 = line_rd[2*PW-1:PW];
    assign mid2 = line_rd[PW-1:0];

    c3sc_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data ({mid2, pixel}),
        .rd_en   (accept),
        .rd_addr (col_next),
        .rd_data (line_rd)
    );

    // Window: 0..2 two columns left, 3..5 one column left (top, mid, bottom)
    logic [PW-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top2;
            win_reg[4] <= mid2;
            win_reg[5] <= pixel;
        end
    end

    // Stage 1: kernel sum
    function automatic logic signed [AW-1:0] sx(input logic [PW-1:0] p);
        return $signed({{(AW-PW){1'b0}}, p});
    endfunction

    logic signed [AW-1:0] acc_next;
    logic                 emit;
    logic                 last_next;

    always_comb
    begin
        acc_next = c3sc_pkg::ACC_OFFSET
                 - AW'(7) * sx(win_reg[0]) + AW'(5)  * sx(win_reg[3]) + AW'(2) * sx(top2)
                 - sx(win_reg[1])          + AW'(15) * sx(win_reg[4]) - sx(mid2)
                 + AW'(2) * sx(win_reg[2]) + AW'(5)  * sx(win_reg[5]) - AW'(7) * sx(pixel);
        emit = (row_reg >= RW'(2)) && (col_reg >= CW'(2))
            && (row_reg < h_use) && (WW'(col_reg) < w_use);
        last_next = (row_reg == h_use - RW'(1)) && (WW'(col_reg) == w_use - WW'(1));
    end

    logic signed [AW-1:0] s1_acc_reg;
    logic [RW-1:0]        s1_row_reg;
    logic [CW-1:0]        s1_col_reg;
    logic                 s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg  <= acc_next;
            s1_row_reg  <= row_reg - RW'(1);
            s1_col_reg  <= col_reg - CW'(1);
            s1_last_reg <= last_next;
        end
    end

    // Stage 2: divide by 13 and clip
    logic [PRW-1:0] quot_prod;
    logic [PW-1:0]  clip_val;

    always_comb
    begin
        quot_prod = PRW'(s1_acc_reg[c3sc_pkg::DIV_IN_W-1:0]) * PRW'(c3sc_pkg::DIV_MUL);
        priority if (s1_acc_reg < 0)
        begin
            clip_val = '0;
        end
        else if (s1_acc_reg >= c3sc_pkg::ACC_SAT)
        begin
            clip_val = '1;
        end
        else
        begin
            clip_val = quot_prod[c3sc_pkg::DIV_SHIFT +: PW];
        end
    end

    logic [PW-1:0] value_reg;
    logic [RW-1:0] out_row_reg;
    logic [CW-1:0] out_col_reg;
    logic          frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            value_reg      <= clip_val;
            out_row_reg    <= s1_row_reg;
            out_col_reg    <= s1_col_reg;
            frame_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for conv3x3_sharpen_clip: random and directed pixel frames,
// every result checked against a built-in model of the sharpening filter.
// Depends on c3sc_pkg and the block's RTL.

module tb;

    localparam int MAX_WIDTH_DEF = c3sc_pkg::MAX_WIDTH_DEF;
    localparam int PIX_W         = c3sc_pkg::PIX_W;
    localparam int ROW_W         = c3sc_pkg::ROW_W;
    localparam int FW_W          = c3sc_pkg::FW_W;
    localparam int FH_W          = c3sc_pkg::FH_W;
    localparam int CFG_IDX_W     = c3sc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = c3sc_pkg::CFG_DATA_W;

    localparam int COL_W       = $clog2(MAX_WIDTH_DEF);
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MODE_ITEMS  = 60;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } filt_pix_t;

    typedef enum logic {STEP_CONFIG, STEP_PIXEL} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [15:0] arg_a;     // pixel, or width word
        logic [15:0] arg_b;     // height word
        logic        typed;
        logic [7:0]  typed_value;
    } dir_step_t;

    // 3x3 frames: one interior pixel per frame, or one per row of a 3x5 frame
    localparam dir_step_t DIR_STEPS [0:27] = '{
        {STEP_CONFIG, 16'd3,     16'd3, 1'b0, 8'd0},
        {STEP_PIXEL,  16'hA5,    16'd0, 1'b0, 8'd0},   // past the row end, wraps
        {STEP_CONFIG, 16'd3,     16'd5, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b1, 8'd0},   // top-left only: clips low
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b1, 8'd255}, // center 255: clips high
        {STEP_CONFIG, 16'hF800,  16'd1, 1'b0, 8'd0},   // both saturate to 3
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd0,     16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b0, 8'd0},
        {STEP_PIXEL,  16'd255,   16'd0, 1'b1, 8'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      value;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  frame_last;

    // filter model state
    logic [FW_W-1:0]  cfg_width = c3sc_pkg::FRAME_WIDTH_RST;
    logic [FH_W-1:0]  cfg_height = c3sc_pkg::FRAME_HEIGHT_RST;
    logic [PIX_W-1:0] line_one [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0] line_two [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0] win [6] = '{default: '0};
    int               pos_col = 0;
    int               pos_row = 0;

    filt_pix_t   pending [$];
    filt_pix_t   got_pix;
    filt_pix_t   want_pix;
    int          errors = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int unsigned cycles = 0;

    conv3x3_sharpen_clip DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got_pix = {value, out_row, out_col, frame_last};
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: expected none, got value=%0d row=%0d col=%0d last=%0b",
                         $time, value, out_row, out_col, frame_last);
            end
            else
            begin
                want_pix = pending.pop_front();
                if (got_pix !== want_pix)
                begin
                    errors++;
                    $display("%0t: expected value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
                             $time, want_pix.value, want_pix.row, want_pix.col,
                             want_pix.last, got_pix.value, got_pix.row, got_pix.col,
                             got_pix.last);
                end
            end
        end
    end

    function automatic bit predict_filtered(input logic [PIX_W-1:0] px, output filt_pix_t res);
        int               w;
        int               h;
        int               idx;
        int               acc;
        int               q;
        int               k [9];
        logic [PIX_W-1:0] t2;
        logic [PIX_W-1:0] m2;
        w = int'(cfg_width);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        h = int'(cfg_height);
        if (h < 3) h = 3;
        idx = (pos_col < MAX_WIDTH_DEF) ? pos_col : MAX_WIDTH_DEF - 1;
        t2 = line_two[idx];
        m2 = line_one[idx];
        k[0] = win[0]; k[1] = win[3]; k[2] = t2;
        k[3] = win[1]; k[4] = win[4]; k[5] = m2;
        k[6] = win[2]; k[7] = win[5]; k[8] = px;
        acc = -7 * k[0] + 5 * k[1] + 2 * k[2]
              - k[3] + 15 * k[4] - k[5]
              + 2 * k[6] + 5 * k[7] - 7 * k[8] + 128;
        q = acc / 13;
        res = '0;
        predict_filtered = 1'b0;
        if (pos_row >= 2 && pos_col >= 2 && pos_row < h && pos_col < w)
        begin
            res.value = (q < 0) ? '0 : (q > 255) ? 8'hFF : q[PIX_W-1:0];
            res.row = ROW_W'(pos_row - 1);
            res.col = COL_W'(pos_col - 1);
            res.last = (pos_row == h - 1 && pos_col == w - 1);
            predict_filtered = 1'b1;
        end
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = t2; win[4] = m2; win[5] = px;
        line_two[idx] = m2;
        line_one[idx] = px;
        if (pos_col + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= h) ? 0 : ((pos_row + 1) & 16'hFFFF);
        end
        else
        begin
            pos_col = pos_col + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px, output bit made);
        filt_pix_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        made = predict_filtered(px, res);
        if (made) pending.push_back(res);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        if (idx == c3sc_pkg::REG_FRAME_WIDTH)
            cfg_width = data[FW_W-1:0];
        else
            cfg_height = data[FH_W-1:0];
    endtask

    task automatic configure(input logic [15:0] width_word, input logic [15:0] height_word);
        wait_idle();
        write_reg(c3sc_pkg::REG_FRAME_WIDTH, width_word);
        write_reg(c3sc_pkg::REG_FRAME_HEIGHT, height_word);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // whole frame, or a frame resized mid-frame to a size no larger than its own
    task automatic run_frame(input int w, input int h);
        int n;
        bit made;
        configure({5'($urandom), 11'(w)}, 16'(h));
        n = w * h;
        if (h >= 4 && $urandom_range(3) == 0)
            n = $urandom_range(w * h - 1, 2 * w + 3);
        repeat (n) send_pixel(rand_pixel(), made);
        if (pos_row != 0 || pos_col != 0)
        begin
            configure({5'($urandom), 11'($urandom_range(w, 3))}, 16'($urandom_range(h, 3)));
            while (pos_row != 0 || pos_col != 0) send_pixel(rand_pixel(), made);
        end
    endtask

    initial
    begin
        int send_pcts [4];
        int stall_pcts [4];
        int mode_start;
        int spins;
        bit made;
        send_pcts = '{0, 50, 0, 29};
        stall_pcts = '{0, 0, 50, 29};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size: two rows and a bit of a 32-wide frame
        repeat (68) send_pixel(rand_pixel(), made);

        foreach (DIR_STEPS[i])
        begin
            if (DIR_STEPS[i].kind == STEP_CONFIG)
            begin
                configure(DIR_STEPS[i].arg_a, DIR_STEPS[i].arg_b);
            end
            else
            begin
                send_pixel(DIR_STEPS[i].arg_a[PIX_W-1:0], made);
                if (made && DIR_STEPS[i].typed)
                    pending[pending.size() - 1].value = DIR_STEPS[i].typed_value;
            end
        end

        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = send_pcts[mode];
            recv_stall_pct <= stall_pcts[mode];
            mode_start = items_sent;
            if (mode == 0)
            begin
                configure(16'd12, 16'd8);
                hold_toggle <= ~hold_toggle;
                repeat (96) send_pixel(rand_pixel(), made);
            end
            while (items_sent - mode_start < MODE_ITEMS)
                run_frame(($urandom_range(4) == 0) ? int'($urandom_range(64, 13))
                                                   : int'($urandom_range(12, 3)),
                          int'($urandom_range(8, 3)));
        end

        // widest frame, width word above the limit: one row and a bit, then
        // a 3x3 size ends the frame
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        configure(16'hFFFF, 16'd3);
        repeat (MAX_WIDTH_DEF + 5) send_pixel(rand_pixel(), made);
        configure(16'd3, 16'd3);
        while (pos_row != 0 || pos_col != 0) send_pixel(rand_pixel(), made);

        // tallest height, cut short: the current row, past the new height, ends the frame
        configure(16'd3, 16'hFFFF);
        repeat (16) send_pixel(rand_pixel(), made);
        configure(16'd3, 16'd3);
        while (pos_row != 0 || pos_col != 0) send_pixel(rand_pixel(), made);

        in_valid <= 1'b0;
        spins = 0;
        while (pending.size() != 0 && spins < 100000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
        if (pending.size() != 0)
        begin
            errors += pending.size();
            $display("%0t: %0d expected results never arrived", $time, pending.size());
        end
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
